// ===== rtl/core/mdm_pkg.sv =====
// ----------------------------------------------------------------------------
// mdm_pkg
// shared types, constants and stick decode for the mecanum drive mixer
// ----------------------------------------------------------------------------
package mdm_pkg;

    localparam int unsigned WHEELS = 4;

    // configuration register indexes
    localparam logic REG_FAST_LIMIT = 1'b0;
    localparam logic REG_PREC_LIMIT = 1'b1;

    localparam logic [7:0] FAST_LIMIT_RST = 8'd255;
    localparam logic [7:0] PREC_LIMIT_RST = 8'd120;

    // wheel direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // divide by three as multiply by reciprocal, exact for products up to 765
    localparam logic [9:0] RECIP3       = 10'd683;
    localparam int unsigned RECIP3_SHIFT = 11;

    typedef struct packed {
        logic [3:0] move_stick;
        logic [3:0] turn_stick;
        logic       fast_key;
        logic       slow_key;
        logic       nudge_up;
        logic       nudge_down;
        logic       nudge_right;
        logic       nudge_left;
    } sample_t;

    typedef struct packed {
        logic [7:0] front_left_duty;
        logic [1:0] front_left_dir;
        logic [7:0] back_left_duty;
        logic [1:0] back_left_dir;
        logic [7:0] front_right_duty;
        logic [1:0] front_right_dir;
        logic [7:0] back_right_duty;
        logic [1:0] back_right_dir;
    } result_t;

    typedef struct packed {
        logic       neg;
        logic [1:0] mag;
    } wheel_t;

    typedef struct packed {
        wheel_t [WHEELS-1:0] wheel;
        logic   [1:0]        peak;
    } mix_t;

    function automatic logic signed [1:0] stick_x(input logic [3:0] code);
        logic signed [1:0] v;
        case (code)
            4'd2, 4'd3, 4'd4: v = 2'sd1;
            4'd6, 4'd7, 4'd8: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] stick_y(input logic [3:0] code);
        logic signed [1:0] v;
        case (code)
            4'd1, 4'd2, 4'd8: v = 2'sd1;
            4'd4, 4'd5, 4'd6: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mdm_mix.sv =====
// ----------------------------------------------------------------------------
// mdm_mix
// decodes sticks and nudge keys, mixes four wheel speeds and finds the peak
// ----------------------------------------------------------------------------
module mdm_mix (
    input  mdm_pkg::sample_t sample,
    output mdm_pkg::mix_t    mix
);
    import mdm_pkg::*;

    logic signed [1:0] sx;
    logic signed [1:0] sy;
    logic signed [1:0] sr;
    logic signed [2:0] tx;
    logic signed [2:0] ty;
    logic signed [2:0] rot;
    logic signed [2:0] spd [WHEELS];
    logic        [2:0] absv [WHEELS];

    always_comb
    begin
        sx  = stick_x(sample.move_stick);
        sy  = stick_y(sample.move_stick);
        sr  = stick_x(sample.turn_stick);
        tx  = {sx[1], sx};
        ty  = {sy[1], sy};
        rot = {sr[1], sr};

        // nudge keys, later checks win
        if (sample.nudge_up)
        begin
            tx = 3'sd0;
            ty = 3'sd1;
        end
        if (sample.nudge_down)
        begin
            tx = 3'sd0;
            ty = -3'sd1;
        end
        if (sample.nudge_right)
        begin
            tx = 3'sd1;
            ty = 3'sd0;
        end
        if (sample.nudge_left)
        begin
            tx = -3'sd1;
            ty = 3'sd0;
        end

        spd[0] = ty + tx + rot;
        spd[1] = ty - tx + rot;
        spd[2] = ty - tx - rot;
        spd[3] = ty + tx - rot;

        mix.peak = 2'd1;
        for (int k = 0; k < WHEELS; k++)
        begin
            absv[k] = spd[k][2] ? 3'(-spd[k]) : 3'(spd[k]);
            mix.wheel[k].neg = spd[k][2];
            mix.wheel[k].mag = absv[k][1:0];
            if (absv[k][1:0] > mix.peak)
            begin
                mix.peak = absv[k][1:0];
            end
        end
    end

endmodule

// ===== rtl/core/mdm_scale_div.sv =====
// ----------------------------------------------------------------------------
// mdm_scale_div
// shared scale and divide unit: speed times limit, then divide by the peak
// ----------------------------------------------------------------------------
module mdm_scale_div (
    input  logic       clk,
    input  logic       mul_en,
    input  logic [1:0] mag,
    input  logic [7:0] limit,
    input  logic [1:0] peak,
    output logic [7:0] quot
);
    import mdm_pkg::*;

    logic [9:0]  prod_reg;
    logic [9:0]  prod_next;
    logic [19:0] prod3;

    assign prod_next = {8'd0, mag} * {2'd0, limit};

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod3 = {10'd0, prod_reg} * {10'd0, RECIP3};

    always_comb
    begin
        case (peak)
            2'd3:    quot = prod3[RECIP3_SHIFT +: 8];
            2'd2:    quot = prod_reg[8:1];
            default: quot = prod_reg[7:0];
        endcase
    end

endmodule

// ===== rtl/core/mecanum_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// mecanum_drive_mixer
// Takes one controller sample per transfer and returns one result transfer
// with duty and direction for the four mecanum wheels. Each sample passes
// through the single shared multiply-and-divide unit, which takes the four
// wheels in turn with a multiply step and a divide step each, before its
// result lands in the output register; only then is a new sample taken. The
// output register lets the next sample start while a result still waits.
// Configuration writes are taken at any time and are meant for idle.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  mdm_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_ready,
    output mdm_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import mdm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  wheel_cnt_reg;
    logic [1:0]  wheel_cnt_next;
    logic        fast_mode_reg;
    logic        fast_mode_next;
    logic [7:0]  fast_limit_reg;
    logic [7:0]  prec_limit_reg;
    logic [7:0]  limit_reg;
    mix_t        mix_reg;
    mix_t        mix_now;
    logic [7:0]  duty_reg [WHEELS];
    logic [1:0]  dir_reg [WHEELS];
    logic        result_valid_reg;
    result_t     result_reg;
    logic        sample_xfer;
    logic        load_result;
    logic        mul_en;
    logic [7:0]  quot;
    wheel_t      cur_wheel;

    assign sample_ready = (state_reg == ST_IDLE);
    assign sample_xfer  = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign mul_en       = (state_reg == ST_MUL);
    assign load_result  = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);
    assign cur_wheel    = mix_reg.wheel[wheel_cnt_reg];

    mdm_mix u_mix (
        .sample (sample),
        .mix    (mix_now)
    );

    mdm_scale_div u_scale_div (
        .clk    (clk),
        .mul_en (mul_en),
        .mag    (cur_wheel.mag),
        .limit  (limit_reg),
        .peak   (mix_reg.peak),
        .quot   (quot)
    );

    // speed mode keys, precision wins
    always_comb
    begin
        fast_mode_next = fast_mode_reg;
        if (sample.fast_key)
        begin
            fast_mode_next = 1'b1;
        end
        if (sample.slow_key)
        begin
            fast_mode_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wheel_cnt_next = wheel_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    state_next     = ST_MUL;
                    wheel_cnt_next = 2'd0;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (wheel_cnt_reg == 2'(WHEELS - 1))
                begin
                    state_next     = ST_DONE;
                    wheel_cnt_next = 2'd0;
                end
                else
                begin
                    state_next     = ST_MUL;
                    wheel_cnt_next = wheel_cnt_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (load_result)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                wheel_cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wheel_cnt_reg    <= 2'd0;
            fast_mode_reg    <= 1'b0;
            fast_limit_reg   <= FAST_LIMIT_RST;
            prec_limit_reg   <= PREC_LIMIT_RST;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wheel_cnt_reg <= wheel_cnt_next;
            if (sample_xfer)
            begin
                fast_mode_reg <= fast_mode_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FAST_LIMIT: fast_limit_reg <= cfg_data;
                    REG_PREC_LIMIT: prec_limit_reg <= cfg_data;
                    default:        fast_limit_reg <= fast_limit_reg;
                endcase
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            mix_reg   <= mix_now;
            limit_reg <= fast_mode_next ? fast_limit_reg : prec_limit_reg;
        end
        if (state_reg == ST_DIV)
        begin
            if (quot == 8'd0)
            begin
                duty_reg[wheel_cnt_reg] <= 8'd0;
                dir_reg[wheel_cnt_reg]  <= DIR_STOP;
            end
            else
            begin
                duty_reg[wheel_cnt_reg] <= quot;
                dir_reg[wheel_cnt_reg]  <= cur_wheel.neg ? DIR_REV : DIR_FWD;
            end
        end
        if (load_result)
        begin
            result_reg.front_left_duty  <= duty_reg[0];
            result_reg.front_left_dir   <= dir_reg[0];
            result_reg.back_left_duty   <= duty_reg[1];
            result_reg.back_left_dir    <= dir_reg[1];
            result_reg.front_right_duty <= duty_reg[2];
            result_reg.front_right_dir  <= dir_reg[2];
            result_reg.back_right_duty  <= duty_reg[3];
            result_reg.back_right_dir   <= dir_reg[3];
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> state_reg == ST_MUL)
        else $error("sample transfer did not start the sequencer");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

    a_stop_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result.front_left_dir == DIR_STOP) == (result.front_left_duty == 8'd0)) &&
            ((result.back_right_dir == DIR_STOP) == (result.back_right_duty == 8'd0)))
        else $error("stop code and zero duty disagree");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> wheel_cnt_reg == 2'd0)
        else $error("wheel counter not cleared in idle");

endmodule

// ===== tb/tb_mecanum_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_mecanum_drive_mixer
// Self-checking bench for the mecanum drive mixer. Controller samples go in
// over a valid/ready channel. An in-bench predictor tracks the speed-mode flag
// and both speed limits, and works out the wheel duty and direction for every
// accepted sample. Each result transfer is checked field by field against the
// oldest prediction. Covers directed corner samples, limit extremes, random
// traffic under changing idle patterns, and a long output stall.
// ----------------------------------------------------------------------------
module tb_mecanum_drive_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import mdm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 20;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       sample_valid = 1'b0;
    logic       sample_ready;
    sample_t    sample       = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic       cfg_index    = REG_FAST_LIMIT;
    logic [7:0] cfg_data     = '0;

    // predictor state
    logic       fast_mode_q  = 1'b0;
    logic [7:0] fast_limit_q = FAST_LIMIT_RST;
    logic [7:0] prec_limit_q = PREC_LIMIT_RST;

    result_t     pending_wheels[$];
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        rx_hold       = 1'b0;
    event        hold_start;
    string       wheel_label[4] = '{"front_left", "back_left", "front_right", "back_right"};

    mecanum_drive_mixer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL mecanum_drive_mixer");
            $finish;
        end
    end

    function automatic void decode_stick(input logic [3:0] code, output int x, output int y);
        case (code)
            4'd1:    begin x = 0;  y = 1;  end
            4'd2:    begin x = 1;  y = 1;  end
            4'd3:    begin x = 1;  y = 0;  end
            4'd4:    begin x = 1;  y = -1; end
            4'd5:    begin x = 0;  y = -1; end
            4'd6:    begin x = -1; y = -1; end
            4'd7:    begin x = -1; y = 0;  end
            4'd8:    begin x = -1; y = 1;  end
            default: begin x = 0;  y = 0;  end
        endcase
    endfunction

    function automatic result_t predict_wheels(input sample_t s);
        int         tx, ty, rot, spare, peak, mag, d;
        int         w[4];
        logic [7:0] lim;
        logic [7:0] duty[4];
        logic [1:0] dir[4];
        result_t    r;
        if (s.fast_key) fast_mode_q = 1'b1;
        if (s.slow_key) fast_mode_q = 1'b0;
        lim = fast_mode_q ? fast_limit_q : prec_limit_q;
        decode_stick(s.move_stick, tx, ty);
        decode_stick(s.turn_stick, rot, spare);
        if (s.nudge_up)    begin tx = 0;  ty = 1;  end
        if (s.nudge_down)  begin tx = 0;  ty = -1; end
        if (s.nudge_right) begin tx = 1;  ty = 0;  end
        if (s.nudge_left)  begin tx = -1; ty = 0;  end
        w[0] = ty + tx + rot;
        w[1] = ty - tx + rot;
        w[2] = ty - tx - rot;
        w[3] = ty + tx - rot;
        peak = 1;
        foreach (w[k])
            if ((w[k] < 0 ? -w[k] : w[k]) > peak) peak = (w[k] < 0 ? -w[k] : w[k]);
        foreach (w[k])
        begin
            mag = (w[k] < 0) ? -w[k] : w[k];
            d = (mag * int'(lim)) / peak;
            if (d == 0)
            begin
                duty[k] = 8'd0;
                dir[k]  = DIR_STOP;
            end
            else
            begin
                duty[k] = d[7:0];
                dir[k]  = (w[k] > 0) ? DIR_FWD : DIR_REV;
            end
        end
        r.front_left_duty  = duty[0];
        r.front_left_dir   = dir[0];
        r.back_left_duty   = duty[1];
        r.back_left_dir    = dir[1];
        r.front_right_duty = duty[2];
        r.front_right_dir  = dir[2];
        r.back_right_duty  = duty[3];
        r.back_right_dir   = dir[3];
        return r;
    endfunction

    function automatic sample_t make_sample(input logic [3:0] move, input logic [3:0] turn,
                                            input logic [1:0] keys, input logic [3:0] nudges);
        sample_t s;
        s.move_stick = move;
        s.turn_stick = turn;
        {s.fast_key, s.slow_key} = keys;
        {s.nudge_up, s.nudge_down, s.nudge_right, s.nudge_left} = nudges;
        return s;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.move_stick  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        s.turn_stick  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        s.fast_key    = ($urandom_range(4) == 0);
        s.slow_key    = ($urandom_range(5) == 0);
        s.nudge_up    = ($urandom_range(7) == 0);
        s.nudge_down  = ($urandom_range(7) == 0);
        s.nudge_right = ($urandom_range(7) == 0);
        s.nudge_left  = ($urandom_range(7) == 0);
        return s;
    endfunction

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(4))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // valid is left high after a transfer; end_burst drops it, the next call only when it idles
    task automatic send_sample(input sample_t s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do @(posedge clk); while (!sample_ready);
        pending_wheels.push_back(predict_wheels(s));
    endtask

    task automatic end_burst();
        sample_valid <= 1'b0;
        while (pending_wheels.size() != 0) @(posedge clk);
    endtask

    task automatic set_limits(input logic [7:0] fast_lim, input logic [7:0] prec_lim);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FAST_LIMIT;
        cfg_data  <= fast_lim;
        do @(posedge clk); while (!cfg_ready);
        fast_limit_q = fast_lim;
        cfg_index <= REG_PREC_LIMIT;
        cfg_data  <= prec_lim;
        do @(posedge clk); while (!cfg_ready);
        prec_limit_q = prec_lim;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_wheels(input result_t got);
        result_t    want;
        logic [7:0] got_duty[4], want_duty[4];
        logic [1:0] got_dir[4], want_dir[4];
        if (pending_wheels.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("[%0t] unexpected result transfer %h", $realtime, got);
            return;
        end
        want = pending_wheels.pop_front();
        got_duty  = '{got.front_left_duty, got.back_left_duty,
                      got.front_right_duty, got.back_right_duty};
        want_duty = '{want.front_left_duty, want.back_left_duty,
                      want.front_right_duty, want.back_right_duty};
        got_dir   = '{got.front_left_dir, got.back_left_dir,
                      got.front_right_dir, got.back_right_dir};
        want_dir  = '{want.front_left_dir, want.back_left_dir,
                      want.front_right_dir, want.back_right_dir};
        for (int k = 0; k < 4; k++)
        begin
            if (got_duty[k] !== want_duty[k])
            begin
                error_count++;
                if (error_count <= 10)
                    $display("[%0t] %s_duty expected %0d got %0d", $realtime,
                             wheel_label[k], want_duty[k], got_duty[k]);
            end
            if (got_dir[k] !== want_dir[k])
            begin
                error_count++;
                if (error_count <= 10)
                    $display("[%0t] %s_dir expected %0d got %0d", $realtime,
                             wheel_label[k], want_dir[k], got_dir[k]);
            end
        end
    endtask

    // result side: checks transfers and draws ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                check_wheels(result);
            if (rx_hold)
                result_ready <= 1'b0;
            else
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long output stall
    initial
    begin
        forever
        begin
            @(hold_start);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int m = 0; m <= 8; m++)
            send_sample(make_sample(4'(m), 4'd0, 2'b00, 4'b0000));
        send_sample(make_sample(4'd12, 4'd0, 2'b00, 4'b0000));
        send_sample(make_sample(4'd15, 4'd0, 2'b00, 4'b0000));
        send_sample(make_sample(4'd0, 4'd3, 2'b00, 4'b0000));
        send_sample(make_sample(4'd0, 4'd7, 2'b00, 4'b0000));
        send_sample(make_sample(4'd0, 4'd10, 2'b00, 4'b0000));
        send_sample(make_sample(4'd2, 4'd3, 2'b00, 4'b0000));
        send_sample(make_sample(4'd6, 4'd0, 2'b00, 4'b1000));
        send_sample(make_sample(4'd0, 4'd0, 2'b00, 4'b0100));
        send_sample(make_sample(4'd0, 4'd3, 2'b00, 4'b0010));
        send_sample(make_sample(4'd0, 4'd0, 2'b00, 4'b0001));
        send_sample(make_sample(4'd5, 4'd0, 2'b00, 4'b1111));
        send_sample(make_sample(4'd1, 4'd0, 2'b10, 4'b0000));
        send_sample(make_sample(4'd0, 4'd7, 2'b00, 4'b0000));
        send_sample(make_sample(4'd1, 4'd0, 2'b11, 4'b0000));
        send_sample(make_sample(4'd15, 4'd15, 2'b11, 4'b1111));
        end_burst();
    endtask

    task automatic test_limit_extremes();
        logic [7:0] fast_set[5] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1};
        logic [7:0] prec_set[5] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd1};
        send_idle_pct = 22;
        recv_idle_pct = 87;
        for (int p = 0; p < 5; p++)
        begin
            set_limits(fast_set[p], prec_set[p]);
            for (int i = 0; i < 20; i++)
                send_sample(random_sample());
            end_burst();
        end
    endtask

    task automatic run_traffic(input int unsigned tx_idle, input int unsigned rx_idle,
                               input int n);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int i = 0; i < n; i++)
        begin
            if (i != 0 && i % 110 == 0)
            begin
                end_burst();
                set_limits(pick_limit(), pick_limit());
            end
            send_sample(random_sample());
        end
        end_burst();
    endtask

    task automatic test_random_traffic();
        run_traffic(22, 87, 330);
        run_traffic(87, 22, 330);
        run_traffic(0, 0, 330);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(8'd200, 8'd77);
        -> hold_start;
        for (int i = 0; i < 30; i++)
            send_sample(random_sample());
        end_burst();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_limit_extremes();
        test_random_traffic();
        test_backpressure();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_wheels.size() == 0)
            $display("PASS mecanum_drive_mixer");
        else
            $display("FAIL mecanum_drive_mixer");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mdm_pkg.sv
rtl/core/mdm_mix.sv
rtl/core/mdm_scale_div.sv
rtl/core/mecanum_drive_mixer.sv
tb/tb_mecanum_drive_mixer.sv
